// ===== rtl/core/portal_frustum_reducer_assert.svh =====
// Assertion macros for the checker file pfr_checker.sv.
`ifndef PORTAL_FRUSTUM_REDUCER_ASSERT_SVH
`define PORTAL_FRUSTUM_REDUCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define PFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("portal_frustum_reducer check failed");

// Next-cycle implication.
`define PFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("portal_frustum_reducer check failed");

`endif

// ===== rtl/core/pfr_pkg.sv =====
`default_nettype none
package pfr_pkg;

   localparam int CAM_W   = 24;
   localparam int AXIS_W  = 16;
   localparam int SCR_W   = 16;
   localparam int MB_W    = 26;
   localparam int DVD_W   = 50;
   localparam int DVS_W   = 25;
   localparam int CSR_W   = 3;

   localparam logic [1:0] SIGN_NONE   = 2'd0;
   localparam logic [1:0] SIGN_FRONT  = 2'd1;
   localparam logic [1:0] SIGN_BEHIND = 2'd2;

   localparam logic [CSR_W-1:0] CSR_EYE     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_SIDE    = 3'd1;
   localparam logic [CSR_W-1:0] CSR_UP      = 3'd2;
   localparam logic [CSR_W-1:0] CSR_VIEW    = 3'd3;
   localparam logic [CSR_W-1:0] CSR_NEAR    = 3'd4;
   localparam logic [CSR_W-1:0] CSR_FRUSTUM = 3'd5;
   localparam logic [CSR_W-1:0] CSR_MODE    = 3'd6;

   function automatic logic [15:0] sat16_f(input logic [63:0] v);
      if ((&v[63:15]) || !(|v[63:15])) begin
         return v[15:0];
      end
      return v[63] ? 16'h8000 : 16'h7FFF;
   endfunction

   function automatic logic [23:0] sat24_f(input logic [63:0] v);
      if ((&v[63:23]) || !(|v[63:23])) begin
         return v[23:0];
      end
      return v[63] ? 24'h800000 : 24'h7FFFFF;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pfr_divider.sv =====
`default_nettype none
module pfr_divider import pfr_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [DVD_W-1:0] dividend,
   input  wire logic signed [DVS_W-1:0] divisor,
   output logic                         done,
   output logic signed [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVS_W:0]    rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W+1:0]  rem_sh;
   logic [DVS_W+1:0]  trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      trial   = rem_sh - {2'b00, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[DVD_W-1] ^ divisor[DVS_W-1];
         quo_in  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
         dvs_in  = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
      end else if (busy_ff) begin
         // one quotient bit a cycle, restoring
         if (!trial[DVS_W+1]) begin
            rem_in = trial[DVS_W:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(-quo_ff) : $signed(quo_ff);

endmodule
`default_nettype wire

// ===== rtl/core/portal_frustum_reducer.sv =====
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    vertex x, y, z, last_vertex
// rsp       out        rsp_valid/rsp_ready    visible, reduced left/right/bottom/top
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One vertex at a time; req_ready is high only while the sequencer is idle.
// Camera transform: 9 products through the shared multiplier.
// Each projection or clip coordinate takes a multiply and a division.
// The response sits in an output register; a stalled rsp holds only the cull step.
// Synchronous reset restores the register defaults and clears the polygon state.
module portal_frustum_reducer import pfr_pkg::*; #(
   parameter int COORD_BITS = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_y,
   input  wire logic signed [COORD_BITS-1:0] req_vertex_z,
   input  wire logic                         req_last_vertex,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_visible,
   output logic signed [SCR_W-1:0]           rsp_reduced_left,
   output logic signed [SCR_W-1:0]           rsp_reduced_right,
   output logic signed [SCR_W-1:0]           rsp_reduced_bottom,
   output logic signed [SCR_W-1:0]           rsp_reduced_top,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_W-1:0]             csr_index,
   input  wire logic [63:0]                  csr_data
);

   localparam int RAY_W  = COORD_BITS + 1;
   localparam int MA_W   = (RAY_W > MB_W) ? RAY_W : MB_W;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = COORD_BITS + 19;
   localparam int EYE_W  = (3 * COORD_BITS > 60) ? 3 * COORD_BITS : 60;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DOT    = 4'd1;
   localparam logic [3:0] S_EVAL   = 4'd2;
   localparam logic [3:0] S_NEXT   = 4'd3;
   localparam logic [3:0] S_PMUL   = 4'd4;
   localparam logic [3:0] S_PDIV   = 4'd5;
   localparam logic [3:0] S_PWAIT  = 4'd6;
   localparam logic [3:0] S_CMUL   = 4'd7;
   localparam logic [3:0] S_CDIV   = 4'd8;
   localparam logic [3:0] S_CWAIT  = 4'd9;
   localparam logic [3:0] S_CSCALE = 4'd10;
   localparam logic [3:0] S_CTRK   = 4'd11;
   localparam logic [3:0] S_CULL   = 4'd12;

   // configuration
   logic [59:0] eye_ff;
   logic [47:0] side_ff, up_ff, view_ff;
   logic [15:0] near_ff;
   logic [63:0] frustum_ff;
   logic        persp_ff;
   logic [EYE_W-1:0] eye_wide;

   // sequencer
   logic [3:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       coord_ff, coord_in;
   logic       proj_pend_ff, proj_pend_in;
   logic       clip_pend_ff, clip_pend_in;
   logic       close_pend_ff, close_pend_in;

   // camera transform
   logic signed [RAY_W-1:0] ray_ff [3];
   logic signed [RAY_W-1:0] ray_in [3];
   logic [1:0] icomp_ff, icomp_in, iaxis_ff, iaxis_in;
   logic [1:0] pcomp_ff, pcomp_in, paxis_ff, paxis_in;
   logic       issue_ff, issue_in, pvld_ff, pvld_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_sum;
   logic [47:0] axis_vec;
   logic signed [AXIS_W-1:0] axis_comp;

   // polygon state
   logic signed [CAM_W-1:0] cam_ff [3];
   logic signed [CAM_W-1:0] cam_in [3];
   logic signed [CAM_W-1:0] first_cam_ff [3];
   logic signed [CAM_W-1:0] first_cam_in [3];
   logic signed [CAM_W-1:0] prev_cam_ff [3];
   logic signed [CAM_W-1:0] prev_cam_in [3];
   logic signed [CAM_W-1:0] clp_ff [3];
   logic signed [CAM_W-1:0] clp_in [3];
   logic signed [CAM_W-1:0] clc_ff [3];
   logic signed [CAM_W-1:0] clc_in [3];
   logic [1:0] first_sign_ff, first_sign_in, prev_sign_ff, prev_sign_in;
   logic signed [SCR_W-1:0] min_s_ff, min_s_in, max_s_ff, max_s_in;
   logic signed [SCR_W-1:0] min_u_ff, min_u_in, max_u_ff, max_u_in;
   logic signed [MB_W-1:0]  xclip_ff, xclip_in;

   // shared multiplier
   logic signed [MA_W-1:0]   ma;
   logic signed [MB_W-1:0]   mb;
   logic signed [PROD_W-1:0] prod_ff;

   // divider
   logic                    div_start;
   logic                    div_done;
   logic signed [DVS_W-1:0] div_dvs;
   logic signed [DVD_W-1:0] div_quot;

   // tracking
   logic                    trk_s_en, trk_u_en;
   logic signed [SCR_W-1:0] trk_s, trk_u;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    vis_ff, vis_in;
   logic signed [SCR_W-1:0] rl_ff, rl_in, rr_ff, rr_in, rb_ff, rb_in, rt_ff, rt_in;

   // scratch
   logic                    front;
   logic [1:0]              sign_now, fs_new;
   logic signed [DVS_W-1:0] dz, kz;
   logic signed [DVS_W-1:0] dxy;
   logic signed [DVD_W-1:0] qclip;
   logic signed [SCR_W-1:0] fl, fr, fb, ft;

   assign eye_wide = EYE_W'(eye_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff     <= '0;
         side_ff    <= '0;
         up_ff      <= '0;
         view_ff    <= '0;
         near_ff    <= 16'd256;
         frustum_ff <= '0;
         persp_ff   <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_EYE:     eye_ff     <= csr_data[59:0];
            CSR_SIDE:    side_ff    <= csr_data[47:0];
            CSR_UP:      up_ff      <= csr_data[47:0];
            CSR_VIEW:    view_ff    <= csr_data[47:0];
            CSR_NEAR:    near_ff    <= csr_data[15:0];
            CSR_FRUSTUM: frustum_ff <= csr_data;
            CSR_MODE:    persp_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      unique case (iaxis_ff)
         2'd0:    axis_vec = side_ff;
         2'd1:    axis_vec = up_ff;
         default: axis_vec = view_ff;
      endcase
      unique case (icomp_ff)
         2'd0:    axis_comp = $signed(axis_vec[15:0]);
         2'd1:    axis_comp = $signed(axis_vec[31:16]);
         default: axis_comp = $signed(axis_vec[47:32]);
      endcase
   end

   pfr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[DVD_W-1:0]),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign front    = !cam_ff[2][CAM_W-1] && (cam_ff[2] != '0);
   assign sign_now = front ? SIGN_FRONT : SIGN_BEHIND;
   assign fs_new   = (first_sign_ff == SIGN_NONE) ? sign_now : first_sign_ff;
   assign dz       = DVS_W'(clc_ff[2]) - DVS_W'(clp_ff[2]);
   assign kz       = DVS_W'(1) - DVS_W'(clp_ff[2]);
   assign dxy      = DVS_W'(clc_ff[{1'b0, coord_ff}]) - DVS_W'(clp_ff[{1'b0, coord_ff}]);
   assign qclip    = (dz == '0) ? '0 : div_quot;
   assign fl       = $signed(frustum_ff[15:0]);
   assign fr       = $signed(frustum_ff[31:16]);
   assign fb       = $signed(frustum_ff[47:32]);
   assign ft       = $signed(frustum_ff[63:48]);

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      coord_in      = coord_ff;
      proj_pend_in  = proj_pend_ff;
      clip_pend_in  = clip_pend_ff;
      close_pend_in = close_pend_ff;
      ray_in        = ray_ff;
      icomp_in      = icomp_ff;
      iaxis_in      = iaxis_ff;
      pcomp_in      = icomp_ff;
      paxis_in      = iaxis_ff;
      issue_in      = issue_ff;
      pvld_in       = 1'b0;
      acc_in        = acc_ff;
      acc_sum       = ((pcomp_ff == 2'd0) ? ACC_W'(0) : acc_ff) + $signed(prod_ff[ACC_W-1:0]);
      cam_in        = cam_ff;
      first_cam_in  = first_cam_ff;
      prev_cam_in   = prev_cam_ff;
      clp_in        = clp_ff;
      clc_in        = clc_ff;
      first_sign_in = first_sign_ff;
      prev_sign_in  = prev_sign_ff;
      xclip_in      = xclip_ff;
      ma            = '0;
      mb            = '0;
      div_start     = 1'b0;
      div_dvs       = DVS_W'(cam_ff[2]);
      trk_s_en      = 1'b0;
      trk_u_en      = 1'b0;
      trk_s         = '0;
      trk_u         = '0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      vis_in        = vis_ff;
      rl_in         = rl_ff;
      rr_in         = rr_ff;
      rb_in         = rb_ff;
      rt_in         = rt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ray_in[0] = RAY_W'(req_vertex_x) - RAY_W'($signed(eye_wide[0 +: COORD_BITS]));
               ray_in[1] = RAY_W'(req_vertex_y)
                         - RAY_W'($signed(eye_wide[COORD_BITS +: COORD_BITS]));
               ray_in[2] = RAY_W'(req_vertex_z)
                         - RAY_W'($signed(eye_wide[2*COORD_BITS +: COORD_BITS]));
               last_in   = req_last_vertex;
               icomp_in  = 2'd0;
               iaxis_in  = 2'd0;
               issue_in  = 1'b1;
               state_in  = S_DOT;
            end
         end
         S_DOT: begin
            ma = MA_W'(ray_ff[icomp_ff]);
            mb = MB_W'(axis_comp);
            pvld_in = issue_ff;
            if (issue_ff) begin
               if (icomp_ff == 2'd2) begin
                  icomp_in = 2'd0;
                  iaxis_in = iaxis_ff + 2'd1;
                  if (iaxis_ff == 2'd2) begin
                     issue_in = 1'b0;
                  end
               end else begin
                  icomp_in = icomp_ff + 2'd1;
               end
            end
            if (pvld_ff) begin
               acc_in = acc_sum;
               if (pcomp_ff == 2'd2) begin
                  cam_in[paxis_ff] = $signed(sat24_f(64'($signed(acc_sum[ACC_W-1:14]))));
                  if (paxis_ff == 2'd2) begin
                     state_in = S_EVAL;
                  end
               end
            end
         end
         S_EVAL: begin
            proj_pend_in  = 1'b0;
            clip_pend_in  = 1'b0;
            close_pend_in = 1'b0;
            if (persp_ff) begin
               if (first_sign_ff == SIGN_NONE) begin
                  first_sign_in = sign_now;
                  first_cam_in  = cam_ff;
               end
               proj_pend_in  = front;
               clip_pend_in  = (prev_sign_ff != SIGN_NONE) && (prev_sign_ff != sign_now);
               clp_in        = prev_cam_ff;
               clc_in        = cam_ff;
               close_pend_in = last_ff && (fs_new != sign_now);
               prev_sign_in  = sign_now;
               prev_cam_in   = cam_ff;
            end else begin
               trk_s_en = 1'b1;
               trk_u_en = 1'b1;
               trk_s    = $signed(sat16_f(64'(cam_ff[0]) << 4));
               trk_u    = $signed(sat16_f(64'(cam_ff[1]) << 4));
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            coord_in = 1'b0;
            priority if (proj_pend_ff) begin
               proj_pend_in = 1'b0;
               state_in     = S_PMUL;
            end else if (clip_pend_ff) begin
               clip_pend_in = 1'b0;
               state_in     = S_CMUL;
            end else if (close_pend_ff) begin
               // closing edge: last vertex back to the first
               close_pend_in = 1'b0;
               clp_in        = cam_ff;
               clc_in        = first_cam_ff;
               state_in      = S_CMUL;
            end else begin
               state_in = last_ff ? S_CULL : S_IDLE;
            end
         end
         S_PMUL: begin
            ma       = MA_W'(cam_ff[{1'b0, coord_ff}]);
            mb       = MB_W'({1'b0, near_ff});
            state_in = S_PDIV;
         end
         S_PDIV: begin
            div_start = 1'b1;
            state_in  = S_PWAIT;
         end
         S_PWAIT: begin
            if (div_done) begin
               trk_s_en = !coord_ff;
               trk_u_en = coord_ff;
               trk_s    = $signed(sat16_f(64'(div_quot)));
               trk_u    = trk_s;
               coord_in = 1'b1;
               state_in = coord_ff ? S_NEXT : S_PMUL;
            end
         end
         S_CMUL: begin
            ma       = MA_W'(dxy);
            mb       = MB_W'(kz);
            state_in = S_CDIV;
         end
         S_CDIV: begin
            div_start = 1'b1;
            div_dvs   = dz;
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (div_done) begin
               xclip_in = MB_W'(clp_ff[{1'b0, coord_ff}]) + $signed(qclip[MB_W-1:0]);
               state_in = S_CSCALE;
            end
         end
         S_CSCALE: begin
            ma       = MA_W'(xclip_ff);
            mb       = MB_W'({1'b0, near_ff});
            state_in = S_CTRK;
         end
         S_CTRK: begin
            trk_s_en = !coord_ff;
            trk_u_en = coord_ff;
            trk_s    = $signed(sat16_f(64'(prod_ff)));
            trk_u    = trk_s;
            coord_in = 1'b1;
            state_in = coord_ff ? S_NEXT : S_CMUL;
         end
         S_CULL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (min_s_ff >= fl || max_s_ff <= fr || min_u_ff >= ft || max_u_ff <= fb) begin
                  vis_in = 1'b0;
                  rl_in  = '0;
                  rr_in  = '0;
                  rb_in  = '0;
                  rt_in  = '0;
               end else begin
                  vis_in = 1'b1;
                  rl_in  = (max_s_ff < fl) ? max_s_ff : fl;
                  rr_in  = (min_s_ff > fr) ? min_s_ff : fr;
                  rb_in  = (min_u_ff > fb) ? min_u_ff : fb;
                  rt_in  = (max_u_ff < ft) ? max_u_ff : ft;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // bounding rectangle; drop the polygon once its transaction is issued
   always_comb begin
      min_s_in = min_s_ff;
      max_s_in = max_s_ff;
      min_u_in = min_u_ff;
      max_u_in = max_u_ff;
      if (trk_s_en) begin
         if (trk_s < min_s_ff) min_s_in = trk_s;
         if (trk_s > max_s_ff) max_s_in = trk_s;
      end
      if (trk_u_en) begin
         if (trk_u < min_u_ff) min_u_in = trk_u;
         if (trk_u > max_u_ff) max_u_in = trk_u;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (state_ff == S_CULL && state_in == S_IDLE)) begin
         min_s_ff      <= 16'sh7FFF;
         max_s_ff      <= 16'sh8000;
         min_u_ff      <= 16'sh7FFF;
         max_u_ff      <= 16'sh8000;
         first_sign_ff <= SIGN_NONE;
         prev_sign_ff  <= SIGN_NONE;
         for (int i = 0; i < 3; i++) begin
            first_cam_ff[i] <= '0;
            prev_cam_ff[i]  <= '0;
         end
      end else begin
         min_s_ff      <= min_s_in;
         max_s_ff      <= max_s_in;
         min_u_ff      <= min_u_in;
         max_u_ff      <= max_u_in;
         first_sign_ff <= first_sign_in;
         prev_sign_ff  <= prev_sign_in;
         first_cam_ff  <= first_cam_in;
         prev_cam_ff   <= prev_cam_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_ff      <= 1'b0;
         pvld_ff       <= 1'b0;
         proj_pend_ff  <= 1'b0;
         clip_pend_ff  <= 1'b0;
         close_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         pvld_ff       <= pvld_in;
         proj_pend_ff  <= proj_pend_in;
         clip_pend_ff  <= clip_pend_in;
         close_pend_ff <= close_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_ff  <= last_in;
      coord_ff <= coord_in;
      ray_ff   <= ray_in;
      icomp_ff <= icomp_in;
      iaxis_ff <= iaxis_in;
      pcomp_ff <= pcomp_in;
      paxis_ff <= paxis_in;
      acc_ff   <= acc_in;
      cam_ff   <= cam_in;
      clp_ff   <= clp_in;
      clc_ff   <= clc_in;
      xclip_ff <= xclip_in;
      prod_ff  <= ma * mb;
      vis_ff   <= vis_in;
      rl_ff    <= rl_in;
      rr_ff    <= rr_in;
      rb_ff    <= rb_in;
      rt_ff    <= rt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_visible        = vis_ff;
   assign rsp_reduced_left   = rl_ff;
   assign rsp_reduced_right  = rr_ff;
   assign rsp_reduced_bottom = rb_ff;
   assign rsp_reduced_top    = rt_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pfr_checker.sv =====
`default_nettype none
`include "portal_frustum_reducer_assert.svh"
module pfr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_visible,
   input wire logic [15:0] rsp_reduced_left,
   input wire logic [15:0] rsp_reduced_right,
   input wire logic [15:0] rsp_reduced_bottom,
   input wire logic [15:0] rsp_reduced_top
);

   // a culled polygon carries all-zero bounds
   `PFR_ASSERT_IMP(a_cull_zero, clock, reset, rsp_valid && !rsp_visible, rsp_reduced_left == 16'd0 && rsp_reduced_right == 16'd0 && rsp_reduced_bottom == 16'd0 && rsp_reduced_top == 16'd0)
   // an accepted vertex keeps the sequencer busy in the next cycle
   `PFR_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   // out of reset: idle and nothing pending
   `PFR_ASSERT_IMP(a_reset, clock, reset, $past(reset), req_ready && !rsp_valid)
   // stalled transaction holds
   `PFR_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_visible) && $stable(rsp_reduced_left) && $stable(rsp_reduced_top))

endmodule

bind portal_frustum_reducer pfr_checker u_pfr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_visible        (rsp_visible),
   .rsp_reduced_left   (rsp_reduced_left),
   .rsp_reduced_right  (rsp_reduced_right),
   .rsp_reduced_bottom (rsp_reduced_bottom),
   .rsp_reduced_top    (rsp_reduced_top)
);
`default_nettype wire

// ===== bench/tb_portal_frustum_reducer.sv =====
`default_nettype none
module tb_portal_frustum_reducer;
   import pfr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CB         = 20;
   localparam int          SETTLE     = 400;
   localparam int          IDLE_LIMIT = 6000;
   localparam logic [CSR_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic              visible;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
      logic signed [15:0] top;
   } bounds_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [CB-1:0] req_vertex_x = '0;
   logic signed [CB-1:0] req_vertex_y = '0;
   logic signed [CB-1:0] req_vertex_z = '0;
   logic                 req_last_vertex = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_visible;
   logic signed [15:0]   rsp_reduced_left, rsp_reduced_right;
   logic signed [15:0]   rsp_reduced_bottom, rsp_reduced_top;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_index = '0;
   logic [63:0]          csr_data = '0;

   portal_frustum_reducer #(.COORD_BITS(CB)) i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // view settings and per-polygon state of the predictor
   logic [63:0] eye_q, side_q, up_q, view_q, near_q, frustum_q, mode_q;
   longint      lo_s, hi_s, lo_u, hi_u;
   logic [1:0]  first_side, prev_side;
   longint      first_cam [3];
   longint      prev_cam [3];

   bounds_type pending_bounds [$];
   int      errors, n_vertices, n_polys, n_visible, n_culled, n_csr, idle_cycles;
   bit      quiet;

   function automatic longint sx(logic [63:0] v, int off, int w);
      longint t;
      t = longint'(v >> off);
      t = t <<< (64 - w);
      return t >>> (64 - w);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_scr(longint v);
      return clamp(v, -32768, 32767);
   endfunction

   function automatic longint axis_dot(longint rx, longint ry, longint rz, logic [63:0] a);
      longint acc;
      acc = rx * sx(a, 0, 16) + ry * sx(a, 16, 16) + rz * sx(a, 32, 16);
      return clamp(acc >>> 14, -8388608, 8388607);
   endfunction

   function automatic void track_screen(longint s, longint u);
      if (s < lo_s) lo_s = s;
      if (s > hi_s) hi_s = s;
      if (u < lo_u) lo_u = u;
      if (u > hi_u) hi_u = u;
   endfunction

   function automatic void clip_to_eps(longint px, longint py, longint pz,
                                       longint cx, longint cy, longint cz);
      longint dz, k, x, y, nn;
      nn = longint'(near_q);
      dz = cz - pz;
      k  = 1 - pz;
      x  = px;
      y  = py;
      if (dz != 0) begin
         x += (k * (cx - px)) / dz;
         y += (k * (cy - py)) / dz;
      end
      track_screen(sat_scr(nn * x), sat_scr(nn * y));
   endfunction

   function automatic void clear_polygon();
      lo_s = 32767;
      hi_s = -32768;
      lo_u = 32767;
      hi_u = -32768;
      first_side = SIGN_NONE;
      prev_side  = SIGN_NONE;
      for (int i = 0; i < 3; i++) begin
         first_cam[i] = 0;
         prev_cam[i]  = 0;
      end
   endfunction

   function automatic void write_setting(logic [CSR_W-1:0] idx, logic [63:0] v);
      case (idx)
         CSR_EYE:     eye_q = v & 64'h0FFF_FFFF_FFFF_FFFF;
         CSR_SIDE:    side_q = v & 64'h0000_FFFF_FFFF_FFFF;
         CSR_UP:      up_q = v & 64'h0000_FFFF_FFFF_FFFF;
         CSR_VIEW:    view_q = v & 64'h0000_FFFF_FFFF_FFFF;
         CSR_NEAR:    near_q = v & 64'hFFFF;
         CSR_FRUSTUM: frustum_q = v;
         CSR_MODE:    mode_q = v & 64'h1;
         default: ;
      endcase
   endfunction

   // camera transform, projection, clipping and the cull at the closing vertex
   function automatic void project_vertex(logic signed [CB-1:0] vx, logic signed [CB-1:0] vy,
                                          logic signed [CB-1:0] vz, logic lv);
      longint    rx, ry, rz, cs, cu, cd, nn, fl, fr, fb, ft;
      logic [1:0] sg;
      bounds_type r;
      rx = longint'(vx) - sx(eye_q, 0, CB);
      ry = longint'(vy) - sx(eye_q, CB, CB);
      rz = longint'(vz) - sx(eye_q, 2 * CB, CB);
      cs = axis_dot(rx, ry, rz, side_q);
      cu = axis_dot(rx, ry, rz, up_q);
      cd = axis_dot(rx, ry, rz, view_q);
      nn = longint'(near_q);
      if (mode_q[0]) begin
         sg = (cd >= 1) ? SIGN_FRONT : SIGN_BEHIND;
         if (first_side == SIGN_NONE) begin
            first_side = sg;
            first_cam[0] = cs;
            first_cam[1] = cu;
            first_cam[2] = cd;
         end
         if (sg == SIGN_FRONT) track_screen(sat_scr(nn * cs / cd), sat_scr(nn * cu / cd));
         if (prev_side != SIGN_NONE && prev_side != sg)
            clip_to_eps(prev_cam[0], prev_cam[1], prev_cam[2], cs, cu, cd);
         prev_side = sg;
         prev_cam[0] = cs;
         prev_cam[1] = cu;
         prev_cam[2] = cd;
      end else begin
         track_screen(sat_scr(cs * 16), sat_scr(cu * 16));
      end
      if (!lv) return;
      if (mode_q[0] && first_side != SIGN_NONE && prev_side != SIGN_NONE &&
          first_side != prev_side)
         clip_to_eps(prev_cam[0], prev_cam[1], prev_cam[2],
                     first_cam[0], first_cam[1], first_cam[2]);
      fl = sx(frustum_q, 0, 16);
      fr = sx(frustum_q, 16, 16);
      fb = sx(frustum_q, 32, 16);
      ft = sx(frustum_q, 48, 16);
      if (lo_s >= fl || hi_s <= fr || lo_u >= ft || hi_u <= fb) begin
         r = '0;
      end else begin
         if (lo_s > fr) fr = lo_s;
         if (hi_s < fl) fl = hi_s;
         if (lo_u > fb) fb = lo_u;
         if (hi_u < ft) ft = hi_u;
         r.visible = 1'b1;
         r.left    = fl[15:0];
         r.right   = fr[15:0];
         r.bottom  = fb[15:0];
         r.top     = ft[15:0];
      end
      pending_bounds.push_back(r);
      clear_polygon();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // result side: random stalls, compare against oldest expectation
   int stall_left = 0;
   always @(posedge clock) begin : rsp_monitor
      bounds_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bounds.size() == 0) begin
            $display("%0t: unexpected transaction on rsp", $time);
            errors++;
         end else begin
            e = pending_bounds.pop_front();
            if (e.visible) n_visible++;
            else n_culled++;
            if (rsp_visible !== e.visible || rsp_reduced_left !== e.left ||
                rsp_reduced_right !== e.right || rsp_reduced_bottom !== e.bottom ||
                rsp_reduced_top !== e.top) begin
               $display("%0t: expected vis=%0d l=%0d r=%0d b=%0d t=%0d", $time,
                        e.visible, e.left, e.right, e.bottom, e.top);
               $display("%0t: actual   vis=%0d l=%0d r=%0d b=%0d t=%0d", $time,
                        rsp_visible, rsp_reduced_left, rsp_reduced_right,
                        rsp_reduced_bottom, rsp_reduced_top);
               errors++;
            end
         end
      end
      if ($urandom_range(0, 499) == 0) quiet = !quiet;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_vertex(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                              logic signed [CB-1:0] z, logic lv);
      int gap;
      gap = (!quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= x;
      req_vertex_y    <= y;
      req_vertex_z    <= z;
      req_last_vertex <= lv;
      do @(posedge clock); while (!req_ready);
      project_vertex(x, y, z, lv);
      n_vertices++;
      if (lv) n_polys++;
   endtask

   // drop valid, let every outstanding result arrive, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_bounds.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_W-1:0] idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      write_setting(idx, v);
      n_csr++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] pack_axis(int x, int y, int z);
      return {16'h0, 16'(z), 16'(y), 16'(x)};
   endfunction

   function automatic logic [63:0] pack_bounds(int l, int r, int b, int t);
      return {16'(t), 16'(b), 16'(r), 16'(l)};
   endfunction

   task automatic load_view(logic [63:0] eye, logic [63:0] sd, logic [63:0] upv,
                            logic [63:0] vw, logic [63:0] nr, logic [63:0] fr, logic md);
      settle();
      csr_write(CSR_EYE, eye);
      csr_write(CSR_SIDE, sd);
      csr_write(CSR_UP, upv);
      csr_write(CSR_VIEW, vw);
      csr_write(CSR_NEAR, nr);
      csr_write(CSR_FRUSTUM, fr);
      csr_write(CSR_MODE, {63'h0, md});
   endtask

   task automatic load_identity(logic [63:0] nr, logic md);
      load_view(64'h0, pack_axis(16384, 0, 0), pack_axis(0, 16384, 0),
                pack_axis(0, 0, 16384), nr, pack_bounds(20000, -20000, -20000, 20000), md);
   endtask

   task automatic test_reset_view();
      // zero axes put every vertex at depth zero: nothing projects, polygon culled
      send_vertex(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 1'b0);
      send_vertex(20'sh80000, 20'sh7FFFF, 20'sh80000, 1'b1);
   endtask

   task automatic test_perspective();
      load_identity(256, 1'b1);
      send_vertex(-80, -80, 160, 1'b0);
      send_vertex(80, -80, 160, 1'b0);
      send_vertex(80, 80, 160, 1'b0);
      send_vertex(-80, 80, 160, 1'b1);
      // straddles the epsilon plane, closing edge crosses it too
      send_vertex(-80, -80, 160, 1'b0);
      send_vertex(80, -80, 160, 1'b0);
      send_vertex(80, 80, -160, 1'b0);
      send_vertex(-80, 80, -160, 1'b1);
      send_vertex(10, 10, -100, 1'b0);
      send_vertex(-10, 10, -100, 1'b1);
      send_vertex(0, 0, 16, 1'b1);
      send_vertex(5, -5, 0, 1'b0);
      send_vertex(5, 5, 1, 1'b1);
      send_vertex(20'sh7FFFF, 20'sh80000, 1, 1'b0);
      send_vertex(20'sh80000, 20'sh7FFFF, 20'sh7FFFF, 1'b1);
      send_vertex(8000, 0, 16, 1'b1);
      load_identity(0, 1'b1);
      send_vertex(30, 30, 40, 1'b1);
      load_identity(65535, 1'b1);
      send_vertex(3, -2, 400, 1'b0);
      send_vertex(-3, 2, -40, 1'b1);
   endtask

   task automatic test_orthographic();
      load_identity(256, 1'b0);
      send_vertex(-100, -50, 70, 1'b0);
      send_vertex(120, 60, -30, 1'b1);
   endtask

   task automatic test_mode_switch();
      // ends in perspective: closing edge applies
      load_identity(256, 1'b1);
      send_vertex(40, 40, 200, 1'b0);
      settle();
      csr_write(CSR_MODE, 64'h0);
      send_vertex(-40, 20, 90, 1'b0);
      settle();
      csr_write(CSR_MODE, 64'h1);
      send_vertex(-40, -40, -200, 1'b1);
      // ends in orthographic: no closing edge
      send_vertex(40, 40, 200, 1'b0);
      send_vertex(40, -40, -200, 1'b0);
      settle();
      csr_write(CSR_MODE, 64'h0);
      send_vertex(-40, 0, 50, 1'b1);
   endtask

   task automatic test_extreme_views();
      load_view(64'hFFFF_FFFF_FFFF_FFFF, pack_axis(-32768, -32768, -32768),
                pack_axis(32767, 32767, 32767), pack_axis(-32768, 32767, -32768),
                64'hFFFF, pack_bounds(32767, -32768, -32768, 32767), 1'b1);
      send_vertex(20'sh80000, 20'sh80000, 20'sh80000, 1'b0);
      send_vertex(20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 1'b1);
      settle();
      csr_write(CSR_SPARE, 64'hDEAD_BEEF_0123_4567);
      load_view(64'h0, pack_axis(16384, 0, 0), pack_axis(0, 16384, 0),
                pack_axis(0, 0, 16384), 256, pack_bounds(-32768, 32767, 32767, -32768), 1'b1);
      send_vertex(-80, -80, 160, 1'b0);
      send_vertex(80, 80, 160, 1'b1);
   endtask

   function automatic logic [63:0] rand_axes(int which);
      int sel, v;
      sel = $urandom_range(0, 3);
      if (sel >= 2) return {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      v = (sel == 1) ? -16384 : 16384;
      case (which)
         0: return pack_axis(v, 0, 0);
         1: return pack_axis(0, v, 0);
         default: return pack_axis(0, 0, v);
      endcase
   endfunction

   task automatic random_view();
      logic [63:0] eye, fr, nr;
      int          w;
      if ($urandom_range(0, 3) == 0)
         eye = {$urandom, $urandom};
      else
         eye = {4'h0, 20'($urandom_range(0, 4000) - 2000), 20'($urandom_range(0, 4000) - 2000),
                20'($urandom_range(0, 4000) - 2000)};
      w  = ($urandom_range(0, 3) == 0) ? 400 : 30000;
      fr = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
         : pack_bounds($urandom_range(0, w), -$urandom_range(0, w), -$urandom_range(0, w),
                       $urandom_range(0, w));
      nr = ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 65535)) : 64'd256;
      load_view(eye, rand_axes(0), rand_axes(1), rand_axes(2), nr, fr,
                $urandom_range(0, 4) != 0);
   endtask

   task automatic test_random();
      int len, target;
      logic signed [CB-1:0] x, y, z;
      target = n_vertices + 440;
      while (n_vertices < target) begin
         random_view();
         repeat (10) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 4) == 0) begin
                  x = CB'($urandom);
                  y = CB'($urandom);
                  z = CB'($urandom);
               end else begin
                  x = CB'($urandom_range(0, 8191) - 4096);
                  y = CB'($urandom_range(0, 8191) - 4096);
                  z = CB'($urandom_range(0, 4095) - 2048);
               end
               send_vertex(x, y, z, i == len - 1);
            end
         end
      end
   endtask

   initial begin
      errors = 0;
      n_vertices = 0;
      n_polys = 0;
      n_visible = 0;
      n_culled = 0;
      n_csr = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      eye_q = 0;
      side_q = 0;
      up_q = 0;
      view_q = 0;
      near_q = 256;
      frustum_q = 0;
      mode_q = 1;
      clear_polygon();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_view();
      test_perspective();
      test_orthographic();
      test_mode_switch();
      test_extreme_views();
      test_random();
      settle();
      $display("Covered %0d vertices in %0d polygons under %0d register writes.",
               n_vertices, n_polys, n_csr);
      $display("Results checked: %0d visible, %0d culled, %0d errors.",
               n_visible, n_culled, errors);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pfr_pkg.sv
rtl/core/pfr_divider.sv
rtl/core/portal_frustum_reducer.sv
rtl/core/pfr_checker.sv
bench/tb_portal_frustum_reducer.sv
